FILE: sv/zpt_pkg.sv
// Shared types and constants for the zigzag pivot tracker.
`timescale 1ns / 1ps

package zpt_pkg;

    localparam int DEF_PIVOT_DEPTH = 32;
    localparam int DEF_PRICE_BITS  = 32;
    localparam int DEF_INDEX_BITS  = 32;

    localparam int THRESH_BITS = 16;
    localparam int OFFSET_BITS = 5;
    localparam int K_BITS      = OFFSET_BITS + 1;
    localparam int FACTOR_BITS = THRESH_BITS + 1;

    localparam logic [FACTOR_BITS-1:0] ONE_Q16      = 17'h10000;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd1966;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 5'd0;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_SEL_BIT   = 2;

    typedef enum logic {
        REG_THRESH = 1'b0,
        REG_OFFSET = 1'b1
    } reg_sel_t;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    typedef enum logic [1:0] {
        PH_UNKNOWN = 2'd0,
        PH_UP      = 2'd1,
        PH_DOWN    = 2'd2
    } phase_t;

endpackage

FILE: sv/zpt_pivot_ring.sv
// Pivot ring storage: price/index memory and a price memory with two read ports.
`timescale 1ns / 1ps

module zpt_pivot_ring #(
    parameter int PIVOT_DEPTH = zpt_pkg::DEF_PIVOT_DEPTH,
    parameter int PRICE_BITS  = zpt_pkg::DEF_PRICE_BITS,
    parameter int INDEX_BITS  = zpt_pkg::DEF_INDEX_BITS
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(PIVOT_DEPTH)-1:0] wr_addr,
    input  logic [PRICE_BITS-1:0]          wr_price,
    input  logic [INDEX_BITS-1:0]          wr_index,
    input  logic                           rd_en,
    input  logic [$clog2(PIVOT_DEPTH)-1:0] rd_line_addr,
    input  logic [$clog2(PIVOT_DEPTH)-1:0] rd_even_addr,
    input  logic [$clog2(PIVOT_DEPTH)-1:0] rd_odd_addr,
    output logic [PRICE_BITS-1:0]          line_price,
    output logic [INDEX_BITS-1:0]          line_index,
    output logic [PRICE_BITS-1:0]          even_price,
    output logic [PRICE_BITS-1:0]          odd_price
);

    localparam int WW = PRICE_BITS + INDEX_BITS;

    logic [WW-1:0]         line_mem [PIVOT_DEPTH];
    logic [PRICE_BITS-1:0] price_mem [PIVOT_DEPTH];

    logic [WW-1:0]         line_q_reg;
    logic [PRICE_BITS-1:0] even_q_reg;
    logic [PRICE_BITS-1:0] odd_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr]  <= {wr_price, wr_index};
            price_mem[wr_addr] <= wr_price;
        end
    end

    // write-first: a read of the entry written at the same edge sees the new data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            line_q_reg <= (wr_en && (wr_addr == rd_line_addr)) ? {wr_price, wr_index}
                                                              : line_mem[rd_line_addr];
            even_q_reg <= (wr_en && (wr_addr == rd_even_addr)) ? wr_price
                                                              : price_mem[rd_even_addr];
            odd_q_reg  <= (wr_en && (wr_addr == rd_odd_addr)) ? wr_price
                                                             : price_mem[rd_odd_addr];
        end
    end

    assign line_price = line_q_reg[WW-1:INDEX_BITS];
    assign line_index = line_q_reg[INDEX_BITS-1:0];
    assign even_price = even_q_reg;
    assign odd_price  = odd_q_reg;

endmodule

FILE: sv/zigzag_pivot_tracker_unit.sv
// Top level of the zigzag pivot tracker: phase machine, pivot ring control, output stage.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                             Handshake
// s_        in         bar_high, bar_low, bar_close, series_start        s_valid / s_ready
// m_        out        line_*, high/low_price, active_price, live_index, m_valid / m_ready
//                      direction
// apb       in/out     psel, penable, pwrite, paddr, pwdata, prdata      pready tied high
//
// One item per cycle sustained while m_ready is high; a taken item passes through the
// state update and ring read stage, then the output register.
// aresetn (synchronous, low) clears phase, bar count, ring head and pivot count; ring
// memories are not cleared, entries beyond the pivot count are never reported.
// m_ready low holds the output register; one more item fits in the read stage, then
// s_ready drops until the output register frees.

module zigzag_pivot_tracker_unit #(
    parameter int PIVOT_DEPTH = zpt_pkg::DEF_PIVOT_DEPTH,
    parameter int PRICE_BITS  = zpt_pkg::DEF_PRICE_BITS,
    parameter int INDEX_BITS  = zpt_pkg::DEF_INDEX_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [PRICE_BITS-1:0]              s_bar_high,
    input  logic [PRICE_BITS-1:0]              s_bar_low,
    input  logic [PRICE_BITS-1:0]              s_bar_close,
    input  logic                               s_series_start,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [PRICE_BITS-1:0]              m_line_price,
    output logic [INDEX_BITS-1:0]              m_line_index,
    output logic                               m_line_is_high,
    output logic [PRICE_BITS-1:0]              m_high_price,
    output logic [PRICE_BITS-1:0]              m_low_price,
    output logic [PRICE_BITS-1:0]              m_active_price,
    output logic [INDEX_BITS-1:0]              m_live_index,
    output logic signed [1:0]                  m_direction,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [zpt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [zpt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [zpt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam int AW = $clog2(PIVOT_DEPTH);
    localparam int TW = $clog2(PIVOT_DEPTH + 1);
    localparam int SW = AW + 8;
    localparam int CW = TW + 7;
    localparam int KW = zpt_pkg::K_BITS;
    localparam int MW = PRICE_BITS + zpt_pkg::FACTOR_BITS;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
    localparam logic [TW-1:0]         TOTAL_MAX = TW'(PIVOT_DEPTH);
    localparam logic [AW-1:0]         HEAD_LAST = AW'(PIVOT_DEPTH - 1);

    function automatic logic [AW-1:0] slot_back(input logic [KW-1:0] k,
                                                 input logic [AW-1:0] head);
        logic [SW-1:0] sum;
        begin
            sum = SW'(head) + SW'(PIVOT_DEPTH) - SW'(1) - SW'(k);
            if (sum >= SW'(PIVOT_DEPTH)) begin
                sum = sum - SW'(PIVOT_DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    function automatic logic k_held(input logic [KW-1:0] k, input logic [TW-1:0] total);
        return CW'(k) < CW'(total);
    endfunction

    // configuration
    logic [zpt_pkg::THRESH_BITS-1:0] thresh_reg;
    logic [zpt_pkg::OFFSET_BITS-1:0] offset_reg;
    logic                            cfg_wr;
    zpt_pkg::reg_sel_t               cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = zpt_pkg::reg_sel_t'(paddr[zpt_pkg::REG_SEL_BIT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= zpt_pkg::THRESH_RESET;
            offset_reg <= zpt_pkg::OFFSET_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                zpt_pkg::REG_THRESH: begin
                    thresh_reg <= pwdata[zpt_pkg::THRESH_BITS-1:0];
                end
                zpt_pkg::REG_OFFSET: begin
                    offset_reg <= pwdata[zpt_pkg::OFFSET_BITS-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            zpt_pkg::REG_THRESH: begin
                prdata = zpt_pkg::APB_DATA_BITS'(thresh_reg);
            end
            zpt_pkg::REG_OFFSET: begin
                prdata = zpt_pkg::APB_DATA_BITS'(offset_reg);
            end
        endcase
    end

    // tracker state
    zpt_pkg::phase_t         phase_reg, phase_next;
    logic [PRICE_BITS-1:0]   high_ext_reg, high_ext_next;
    logic [PRICE_BITS-1:0]   low_ext_reg, low_ext_next;
    logic [INDEX_BITS-1:0]   high_idx_reg, high_idx_next;
    logic [INDEX_BITS-1:0]   low_idx_reg, low_idx_next;
    logic [INDEX_BITS-1:0]   count_reg, count_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [TW-1:0]           total_reg, total_next;
    logic                    newest_high_reg, newest_high_next;
    logic [PRICE_BITS-1:0]   newest_price_reg, newest_price_next;

    // read stage
    logic                    p1_valid_reg, p1_valid_next;
    logic                    p1_line_ok_reg, p1_line_ok_next;
    logic                    p1_line_high_reg, p1_line_high_next;
    logic                    p1_high_ok_reg, p1_high_ok_next;
    logic                    p1_low_ok_reg, p1_low_ok_next;
    logic                    p1_high_odd_reg, p1_high_odd_next;
    logic [PRICE_BITS-1:0]   p1_act_price_reg, p1_act_price_next;
    logic [INDEX_BITS-1:0]   p1_act_index_reg, p1_act_index_next;
    logic signed [1:0]       p1_dir_reg, p1_dir_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [PRICE_BITS-1:0]   m_line_price_reg, m_line_price_next;
    logic [INDEX_BITS-1:0]   m_line_index_reg, m_line_index_next;
    logic                    m_line_high_reg, m_line_high_next;
    logic [PRICE_BITS-1:0]   m_high_price_reg, m_high_price_next;
    logic [PRICE_BITS-1:0]   m_low_price_reg, m_low_price_next;
    logic [PRICE_BITS-1:0]   m_act_price_reg, m_act_price_next;
    logic [INDEX_BITS-1:0]   m_act_index_reg, m_act_index_next;
    logic signed [1:0]       m_dir_reg, m_dir_next;

    // ring port
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [PRICE_BITS-1:0]   wr_price;
    logic [INDEX_BITS-1:0]   wr_index;
    logic [AW-1:0]           rd_line_addr, rd_even_addr, rd_odd_addr;
    logic [PRICE_BITS-1:0]   ring_line_price, ring_even_price, ring_odd_price;
    logic [INDEX_BITS-1:0]   ring_line_index;

    // update terms
    logic                               s_accept, p1_adv;
    logic                               first_bar, blank;
    logic                               upd_hi, upd_lo;
    logic [PRICE_BITS-1:0]              hi_ext_u, lo_ext_u;
    logic [INDEX_BITS-1:0]              hi_idx_u, lo_idx_u;
    logic [zpt_pkg::FACTOR_BITS-1:0]    up_factor, dn_factor;
    logic [MW-1:0]                      close_sc, prod_up, prod_dn;
    logic                               cond_low, cond_high, confirm_low, confirm_high;
    logic [PRICE_BITS-1:0]              push_price;
    logic [INDEX_BITS-1:0]              push_idx;
    logic                               push_high, same_type, repl;
    logic [KW-1:0]                      k_line, k_even, k_odd;

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    assign up_factor = zpt_pkg::ONE_Q16 + zpt_pkg::FACTOR_BITS'(thresh_reg);
    assign dn_factor = zpt_pkg::ONE_Q16 - zpt_pkg::FACTOR_BITS'(thresh_reg);

    assign first_bar = s_series_start || (count_reg == '0);
    assign blank     = first_bar || (thresh_reg == '0);

    assign upd_hi   = (phase_reg != zpt_pkg::PH_DOWN) && (s_bar_high >= high_ext_reg);
    assign upd_lo   = (phase_reg != zpt_pkg::PH_UP) && (s_bar_low <= low_ext_reg);
    assign hi_ext_u = upd_hi ? s_bar_high : high_ext_reg;
    assign lo_ext_u = upd_lo ? s_bar_low : low_ext_reg;
    assign hi_idx_u = upd_hi ? count_reg : high_idx_reg;
    assign lo_idx_u = upd_lo ? count_reg : low_idx_reg;

    assign close_sc = MW'({s_bar_close, 16'h0000});
    assign prod_up  = MW'(lo_ext_u) * MW'(up_factor);
    assign prod_dn  = MW'(hi_ext_u) * MW'(dn_factor);

    assign cond_low  = (phase_reg != zpt_pkg::PH_UP) && (lo_ext_u != '0) && !upd_lo
                       && (low_idx_reg < count_reg) && (close_sc >= prod_up);
    assign cond_high = (phase_reg != zpt_pkg::PH_DOWN) && (hi_ext_u != '0) && !upd_hi
                       && (high_idx_reg < count_reg) && (close_sc <= prod_dn);
    assign confirm_low  = cond_low;
    assign confirm_high = cond_high && !cond_low;

    assign push_high  = !confirm_low;
    assign push_price = confirm_low ? lo_ext_u : hi_ext_u;
    assign push_idx   = confirm_low ? lo_idx_u : hi_idx_u;
    assign same_type  = (total_reg != '0) && (newest_high_reg == push_high);
    assign repl       = push_high ? (push_price >= newest_price_reg)
                                  : (push_price <= newest_price_reg);

    assign k_line = KW'(offset_reg);
    assign k_even = {offset_reg, 1'b0};
    assign k_odd  = {offset_reg, 1'b1};

    always_comb begin
        phase_next        = phase_reg;
        high_ext_next     = high_ext_reg;
        low_ext_next      = low_ext_reg;
        high_idx_next     = high_idx_reg;
        low_idx_next      = low_idx_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        total_next        = total_reg;
        newest_high_next  = newest_high_reg;
        newest_price_next = newest_price_reg;
        wr_en             = 1'b0;
        wr_addr           = head_reg;
        wr_price          = push_price;
        wr_index          = push_idx;

        if (s_accept) begin
            if (first_bar) begin
                phase_next    = zpt_pkg::PH_UNKNOWN;
                high_ext_next = s_bar_high;
                low_ext_next  = s_bar_low;
                high_idx_next = '0;
                low_idx_next  = '0;
                count_next    = INDEX_BITS'(1);
                head_next     = '0;
                total_next    = '0;
            end else begin
                count_next    = (count_reg == INDEX_MAX) ? count_reg : count_reg + 1'b1;
                high_ext_next = hi_ext_u;
                low_ext_next  = lo_ext_u;
                high_idx_next = hi_idx_u;
                low_idx_next  = lo_idx_u;
                if (confirm_low) begin
                    phase_next    = zpt_pkg::PH_UP;
                    high_ext_next = s_bar_high;
                    high_idx_next = count_reg;
                end else if (confirm_high) begin
                    phase_next   = zpt_pkg::PH_DOWN;
                    low_ext_next = s_bar_low;
                    low_idx_next = count_reg;
                end
                if (confirm_low || confirm_high) begin
                    if (same_type) begin
                        if (repl) begin
                            wr_en             = 1'b1;
                            wr_addr           = slot_back('0, head_reg);
                            newest_price_next = push_price;
                        end
                    end else begin
                        wr_en             = 1'b1;
                        newest_high_next  = push_high;
                        newest_price_next = push_price;
                        head_next  = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                        total_next = (total_reg == TOTAL_MAX) ? total_reg
                                                              : total_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign rd_line_addr = slot_back(k_line, head_next);
    assign rd_even_addr = slot_back(k_even, head_next);
    assign rd_odd_addr  = slot_back(k_odd, head_next);

    always_comb begin
        p1_line_ok_next   = !blank && k_held(k_line, total_next);
        p1_line_high_next = newest_high_next ^ offset_reg[0];
        p1_high_odd_next  = !newest_high_next;
        p1_high_ok_next   = !blank && k_held(newest_high_next ? k_even : k_odd, total_next);
        p1_low_ok_next    = !blank && k_held(newest_high_next ? k_odd : k_even, total_next);
        p1_act_price_next = '0;
        p1_act_index_next = '0;
        p1_dir_next       = zpt_pkg::DIR_NONE;
        if (!blank && (offset_reg == '0)) begin
            if (phase_next == zpt_pkg::PH_UP) begin
                p1_act_price_next = high_ext_next;
                p1_act_index_next = high_idx_next;
                p1_dir_next       = zpt_pkg::DIR_UP;
            end else if (phase_next == zpt_pkg::PH_DOWN) begin
                p1_act_price_next = low_ext_next;
                p1_act_index_next = low_idx_next;
                p1_dir_next       = zpt_pkg::DIR_DOWN;
            end
        end
        p1_valid_next = s_accept ? 1'b1 : (p1_adv ? 1'b0 : p1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= zpt_pkg::PH_UNKNOWN;
            count_reg       <= '0;
            head_reg        <= '0;
            total_reg       <= '0;
            newest_high_reg <= 1'b0;
            p1_valid_reg    <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            total_reg       <= total_next;
            newest_high_reg <= newest_high_next;
            p1_valid_reg    <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_ext_reg     <= high_ext_next;
        low_ext_reg      <= low_ext_next;
        high_idx_reg     <= high_idx_next;
        low_idx_reg      <= low_idx_next;
        newest_price_reg <= newest_price_next;
        if (s_accept) begin
            p1_line_ok_reg   <= p1_line_ok_next;
            p1_line_high_reg <= p1_line_high_next;
            p1_high_ok_reg   <= p1_high_ok_next;
            p1_low_ok_reg    <= p1_low_ok_next;
            p1_high_odd_reg  <= p1_high_odd_next;
            p1_act_price_reg <= p1_act_price_next;
            p1_act_index_reg <= p1_act_index_next;
            p1_dir_reg       <= p1_dir_next;
        end
    end

    zpt_pivot_ring #(
        .PIVOT_DEPTH (PIVOT_DEPTH),
        .PRICE_BITS  (PRICE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_ring (
        .aclk         (aclk),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_price     (wr_price),
        .wr_index     (wr_index),
        .rd_en        (s_accept),
        .rd_line_addr (rd_line_addr),
        .rd_even_addr (rd_even_addr),
        .rd_odd_addr  (rd_odd_addr),
        .line_price   (ring_line_price),
        .line_index   (ring_line_index),
        .even_price   (ring_even_price),
        .odd_price    (ring_odd_price)
    );

    always_comb begin
        m_line_price_next = p1_line_ok_reg ? ring_line_price : '0;
        m_line_index_next = p1_line_ok_reg ? ring_line_index : '0;
        m_line_high_next  = p1_line_ok_reg && p1_line_high_reg;
        m_high_price_next = !p1_high_ok_reg ? '0
                          : (p1_high_odd_reg ? ring_odd_price : ring_even_price);
        m_low_price_next  = !p1_low_ok_reg ? '0
                          : (p1_high_odd_reg ? ring_even_price : ring_odd_price);
        m_act_price_next  = p1_act_price_reg;
        m_act_index_next  = p1_act_index_reg;
        m_dir_next        = p1_dir_reg;
        m_valid_next      = p1_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_line_price_reg <= m_line_price_next;
            m_line_index_reg <= m_line_index_next;
            m_line_high_reg  <= m_line_high_next;
            m_high_price_reg <= m_high_price_next;
            m_low_price_reg  <= m_low_price_next;
            m_act_price_reg  <= m_act_price_next;
            m_act_index_reg  <= m_act_index_next;
            m_dir_reg        <= m_dir_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_line_price   = m_line_price_reg;
    assign m_line_index   = m_line_index_reg;
    assign m_line_is_high = m_line_high_reg;
    assign m_high_price   = m_high_price_reg;
    assign m_low_price    = m_low_price_reg;
    assign m_active_price = m_act_price_reg;
    assign m_live_index   = m_act_index_reg;
    assign m_direction    = m_dir_reg;

    a_first_bar_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && first_bar |=> (phase_reg == zpt_pkg::PH_UNKNOWN) && (total_reg == '0)
                                  && (count_reg == INDEX_BITS'(1)))
        else $error("first bar did not clear tracker state");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken while read stage is blocked");

    a_new_pivot_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !first_bar && wr_en && !same_type
        |=> (total_reg != '0) && (newest_high_reg == $past(push_high)))
        else $error("new pivot not recorded as newest");

    a_read_stage_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_adv |=> m_valid_reg)
        else $error("advanced item did not reach the output register");

endmodule
